/* design/char_stream_lexer_top_macros.svh */
// ----------------------------------------------------------------------------
// char_stream_lexer_top_macros.svh
// Assertion macros shared by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_LEXER_TOP_MACROS_SVH
`define CHAR_STREAM_LEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CSL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/csl_pkg.sv */
// ----------------------------------------------------------------------------
// csl_pkg
// Types, character constants and classifiers for the byte stream lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam logic [7:0]  CH_SEMI    = 8'h3B;
    localparam logic [7:0]  CH_PERIOD  = 8'h2E;
    localparam logic [7:0]  CH_HYPHEN  = 8'h2D;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [30:0] INT_MAX31  = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_SYMBOL  = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_INT     = 3'd3,
        KIND_COMMENT = 3'd4
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_INT     = 2'd2,
        MODE_COMMENT = 2'd3
    } lex_mode_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  chr;
        logic [30:0] value;
        logic        ovf;
        logic        tend;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        lex_mode_t mode;
    } front_status_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c inside {[8'h30:8'h39]});
    endfunction

endpackage

/* design/csl_front.sv */
// ----------------------------------------------------------------------------
// csl_front
// Lexer state machine: classifies each beat and builds a queue entry of up
// to two results.
// ----------------------------------------------------------------------------
module csl_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             ch,
    input  logic                   eoi,
    output logic                   push,
    output csl_pkg::entry_t        entry,
    output csl_pkg::front_status_t status
);

    csl_pkg::lex_mode_t mode_reg, mode_next;
    logic [7:0]         held_reg, held_next;
    logic [30:0]        acc_reg, acc_next;
    logic               sat_reg, sat_next;

    logic               c_space, c_semi, c_period, c_alpha, c_digit, c_ident_cont;
    logic               fresh_emit;
    csl_pkg::result_t   fresh_res;
    logic [3:0]         digit;
    logic [34:0]        acc_mul;

    assign c_space      = csl_pkg::is_space(ch);
    assign c_semi       = (ch == csl_pkg::CH_SEMI);
    assign c_period     = (ch == csl_pkg::CH_PERIOD);
    assign c_alpha      = csl_pkg::is_alpha(ch);
    assign c_digit      = csl_pkg::is_digit(ch);
    assign c_ident_cont = c_alpha || c_digit || (ch == csl_pkg::CH_HYPHEN) || c_period;
    assign digit        = 4'(ch - csl_pkg::CH_ZERO);
    assign acc_mul      = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                        + {31'd0, digit};

    // result of a byte seen from idle
    always_comb begin
        fresh_emit     = !c_space && !c_alpha && !c_digit;
        fresh_res      = '0;
        fresh_res.tend = 1'b1;
        fresh_res.last = 1'b1;
        if (c_semi || c_period) begin
            fresh_res.kind = csl_pkg::KIND_SYMBOL;
            fresh_res.chr  = ch;
        end else begin
            fresh_res.kind = csl_pkg::KIND_INVALID;
        end
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        if (accept) begin
            logic do_fresh;
            do_fresh = 1'b0;
            case (mode_reg)
                csl_pkg::MODE_IDENT: begin
                    if (!eoi && c_ident_cont) begin
                        held_next = ch;
                    end else begin
                        held_next = '0;
                        mode_next = csl_pkg::MODE_IDLE;
                        do_fresh  = !eoi;
                    end
                end
                csl_pkg::MODE_INT: begin
                    if (!eoi && c_digit) begin
                        if (acc_mul > {4'd0, csl_pkg::INT_MAX31}) begin
                            acc_next = csl_pkg::INT_MAX31;
                            sat_next = 1'b1;
                        end else begin
                            acc_next = acc_mul[30:0];
                        end
                    end else begin
                        acc_next  = '0;
                        sat_next  = 1'b0;
                        mode_next = csl_pkg::MODE_IDLE;
                        do_fresh  = !eoi;
                    end
                end
                csl_pkg::MODE_COMMENT: begin
                    if (eoi || ch == csl_pkg::CH_NEWLINE) begin
                        mode_next = csl_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    mode_next = csl_pkg::MODE_IDLE;
                    do_fresh  = !eoi;
                end
            endcase
            if (do_fresh) begin
                if (c_semi) begin
                    mode_next = csl_pkg::MODE_COMMENT;
                end else if (c_alpha) begin
                    held_next = ch;
                    mode_next = csl_pkg::MODE_IDENT;
                end else if (c_digit) begin
                    acc_next  = {27'd0, digit};
                    sat_next  = 1'b0;
                    mode_next = csl_pkg::MODE_INT;
                end
            end
        end
    end

    // outputs
    always_comb begin
        push           = 1'b0;
        entry          = '0;
        entry.r0.last  = 1'b1;
        entry.r1.last  = 1'b1;
        case (mode_reg)
            csl_pkg::MODE_IDENT: begin
                push          = accept;
                entry.r0.kind = csl_pkg::KIND_IDENT;
                entry.r0.chr  = held_reg;
                if (!eoi && c_ident_cont) begin
                    entry.r0.tend = 1'b0;
                end else begin
                    entry.r0.tend = 1'b1;
                    entry.two     = !eoi && fresh_emit;
                    entry.r1      = fresh_res;
                end
            end
            csl_pkg::MODE_INT: begin
                push          = accept && (eoi || !c_digit);
                entry.r0.kind = csl_pkg::KIND_INT;
                entry.r0.value = acc_reg;
                entry.r0.ovf  = sat_reg;
                entry.r0.tend = 1'b1;
                entry.two     = !eoi && fresh_emit;
                entry.r1      = fresh_res;
            end
            csl_pkg::MODE_COMMENT: begin
                push          = accept;
                entry.r0.kind = csl_pkg::KIND_COMMENT;
                if (eoi || ch == csl_pkg::CH_NEWLINE) begin
                    entry.r0.tend = 1'b1;
                end else begin
                    entry.r0.chr  = ch;
                end
            end
            default: begin
                push     = accept && !eoi && fresh_emit;
                entry.r0 = fresh_res;
            end
        endcase
        entry.r0.last = !entry.two;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= csl_pkg::MODE_IDLE;
            held_reg <= '0;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
            sat_reg  <= sat_next;
        end
    end

    assign status.mode = mode_reg;

endmodule

/* design/csl_queue.sv */
// ----------------------------------------------------------------------------
// csl_queue
// Small FIFO of result entries between the lexer front and the output side.
// ----------------------------------------------------------------------------
module csl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  csl_pkg::entry_t        wr_data,
    input  logic                   pop,
    output csl_pkg::entry_t        rd_data,
    output csl_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    csl_pkg::entry_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_data      = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* design/csl_back.sv */
// ----------------------------------------------------------------------------
// csl_back
// Drains queue entries one result per beat into the output register.
// ----------------------------------------------------------------------------
module csl_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  csl_pkg::entry_t        rd_data,
    input  csl_pkg::queue_status_t q_status,
    output logic                   pop,
    input  logic                   m_ready,
    output logic                   m_valid,
    output csl_pkg::result_t       m_result
);

    logic             sel_reg, sel_next;
    logic             valid_reg, valid_next;
    csl_pkg::result_t res_reg, res_next;
    logic             load;

    assign load = (!valid_reg || m_ready) && !q_status.empty;
    assign pop  = load && (sel_reg || !rd_data.two);

    always_comb begin
        sel_next   = sel_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (!valid_reg || m_ready) begin
            valid_next = !q_status.empty;
        end
        if (load) begin
            res_next = sel_reg ? rd_data.r1 : rd_data.r0;
            sel_next = !pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = res_reg;

endmodule

/* design/char_stream_lexer_top.sv */
// ----------------------------------------------------------------------------
// char_stream_lexer_top
// Byte stream lexer: identifiers, integers, symbols and comments.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the entry queue (QUEUE_DEPTH) has room.
// A beat's first result passes through the entry queue and then the output
// register before it appears on m_. Results leave one per cycle while results
// are queued and m_tready is high; the queue absorbs a beat with two results.
// Reset clears the lexer mode, the queue pointers and the output valid.
`include "char_stream_lexer_top_macros.svh"

module char_stream_lexer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] token_char, [38:8] int_value,
                                   // [39] int_overflow, [40] token_end, zero pad
    output logic [2:0]  m_tuser,   // token_kind
    output logic        m_tlast    // run_last
);

    logic                   accept;
    logic                   push, pop;
    csl_pkg::entry_t        wr_entry, rd_entry;
    csl_pkg::queue_status_t q_status;
    csl_pkg::front_status_t f_status;
    csl_pkg::result_t       result;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    csl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata),
        .eoi     (s_tlast),
        .push    (push),
        .entry   (wr_entry),
        .status  (f_status)
    );

    csl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .status  (q_status)
    );

    csl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_data  (rd_entry),
        .q_status (q_status),
        .pop      (pop),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_result (result)
    );

    assign m_tdata = {7'd0, result.tend, result.ovf, result.value, result.chr};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

    `CSL_ASSERT_NEXT(a_eoi_idle, aclk, aresetn, accept && s_tlast, f_status.mode == csl_pkg::MODE_IDLE, "lexer not idle after end of input")
    `CSL_ASSERT_NOW(a_int_fields, aclk, aresetn, m_tvalid && m_tuser != csl_pkg::KIND_INT, m_tdata[39:8] == 32'd0, "integer fields set on non-integer result")
    `CSL_ASSERT_NOW(a_token_end, aclk, aresetn, m_tvalid && m_tuser != csl_pkg::KIND_IDENT && m_tuser != csl_pkg::KIND_COMMENT, m_tdata[40], "single-piece token without token end")

endmodule
